// ----- sv/fmart_pkg.sv -----
// package for the first-match access rule table
// shared constants, action and status codes, command and status structs
`timescale 1ns / 1ps

package fmart_pkg;

    localparam int MaxRulesDefault   = 64;
    localparam int LabelCountDefault = 64;
    localparam int LabelW            = 6;
    localparam int MaskW             = 8;
    localparam int CountW            = 32;
    localparam int RuleCountW        = 7;
    localparam int EntryW            = 2 * LabelW + 2 + MaskW;

    localparam logic [1:0] ActCheck  = 2'd0;
    localparam logic [1:0] ActAppend = 2'd1;
    localparam logic [1:0] ActFlush  = 2'd2;
    localparam logic [1:0] ActRead   = 2'd3;

    localparam logic [1:0] StOk   = 2'd0;
    localparam logic [1:0] StFull = 2'd1;
    localparam logic [1:0] StIdx  = 2'd2;

    typedef struct packed {
        logic [LabelW-1:0] subj;
        logic              subj_any;
        logic [LabelW-1:0] obj;
        logic              obj_any;
        logic [MaskW-1:0]  mask;
    } t_rule;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic rd_issue;
        logic do_append;
        logic do_flush;
        logic clr_step;
        logic cnt_rd;
        logic cnt_wr;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic full;
        logic idx_bad;
        logic clr_done;
    } t_stat;

    function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

endpackage

// ----- sv/fmart_datapath.sv -----
// datapath of the rule table: rule memory, counter memories, scan and result
// depends on fmart_pkg, driven by fmart_ctrl commands
`timescale 1ns / 1ps

module fmart_datapath import fmart_pkg::*; #(
    parameter int MAX_RULES   = MaxRulesDefault,
    parameter int LABEL_COUNT = LabelCountDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic [29:0] i_data,
    output logic [103:0] o_result
);
    localparam int IdxW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int TotW = $clog2(MAX_RULES + 1);

    t_rule             r_rules [MAX_RULES];
    logic [CountW-1:0] r_allow [MAX_RULES];
    logic [CountW-1:0] r_deny  [MAX_RULES];

    logic [1:0]        r_act;
    logic [LabelW-1:0] r_subj, r_obj;
    logic              r_subj_any, r_obj_any;
    logic [MaskW-1:0]  r_opm;
    logic [LabelW-1:0] r_ridx;
    logic [TotW-1:0]   r_total;
    logic [TotW-1:0]   r_pos;
    logic [IdxW-1:0]   r_clr;
    t_rule             r_rd_rule;
    logic              r_rd_ok;
    logic              r_pfound, r_dfound;
    logic [IdxW-1:0]   r_pidx, r_didx;
    logic [CountW-1:0] r_cnt_a, r_cnt_d;
    logic [CountW-1:0] r_allow_tot, r_deny_tot;
    logic              r_permit, r_found, r_rd_stat;
    logic [IdxW-1:0]   r_hit;

    logic              w_lab, w_any_ok;
    logic [IdxW-1:0]   w_pos_i, w_tgt, w_tot_i, w_cnt_addr;

    assign w_pos_i = r_pos[IdxW-1:0];
    assign w_tot_i = r_total[IdxW-1:0];

    function automatic logic side_ok(input logic [LabelW-1:0] l, input logic a,
                                     input logic [LabelW-1:0] q);
        return a || ((32'(l) < LABEL_COUNT) && (l == q));
    endfunction

    assign w_lab    = side_ok(r_rd_rule.subj, r_rd_rule.subj_any, r_subj) &&
                      side_ok(r_rd_rule.obj, r_rd_rule.obj_any, r_obj);
    assign w_any_ok = |(r_rd_rule.mask & r_opm);
    assign w_tgt    = r_pfound ? r_pidx : r_didx;
    // counters of the rule read back, else of the credited rule
    assign w_cnt_addr = (r_act == ActRead) ? w_pos_i : w_tgt;

    assign o_stat.scan_done = (r_pos >= r_total);
    assign o_stat.full      = (32'(r_total) >= MAX_RULES);
    assign o_stat.idx_bad   = (32'(r_ridx) >= 32'(r_total)) || (32'(r_ridx) >= MAX_RULES);
    assign o_stat.clr_done  = (32'(r_clr) == MAX_RULES - 1);

    always_ff @(posedge i_clk) begin
        r_rd_rule <= r_rules[w_pos_i];
        r_cnt_a   <= r_allow[w_cnt_addr];
        r_cnt_d   <= r_deny[w_cnt_addr];
        if (i_cmd.do_append && !o_stat.full) begin
            r_rules[w_tot_i] <= t_rule'({r_subj, r_subj_any, r_obj, r_obj_any, r_opm});
        end
        if (i_cmd.clr_step) begin
            r_allow[r_clr] <= '0;
            r_deny[r_clr]  <= '0;
        end else if (i_cmd.do_append && !o_stat.full) begin
            r_allow[w_tot_i] <= '0;
            r_deny[w_tot_i]  <= '0;
        end else if (i_cmd.cnt_wr && r_found) begin
            if (r_permit) r_allow[r_hit] <= sat_inc(r_cnt_a);
            else          r_deny[r_hit]  <= sat_inc(r_cnt_d);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_pos       <= '0;
            r_clr       <= '0;
            r_allow_tot <= '0;
            r_deny_tot  <= '0;
            r_pfound    <= 1'b0;
            r_dfound    <= 1'b0;
            r_rd_ok     <= 1'b0;
        end else begin
            r_clr <= i_cmd.clr_step ? r_clr + 1'b1 : '0;
            if (i_cmd.load) begin
                {r_act, r_subj, r_subj_any, r_obj, r_obj_any, r_opm, r_ridx} <= i_data;
                r_pos    <= (i_data[29:28] == ActRead) ? TotW'(i_data[5:0]) : '0;
                r_pfound <= 1'b0;
                r_dfound <= 1'b0;
            end
            if (i_cmd.load || i_cmd.scan_start) r_rd_ok <= 1'b0;
            if (i_cmd.scan_step) begin
                r_rd_ok <= 1'b1;
                if (r_rd_ok) begin
                    if (w_lab && w_any_ok && !r_pfound) begin
                        r_pfound <= 1'b1;
                        r_pidx   <= w_pos_i - 1'b1;
                    end
                    if (w_lab && !r_dfound) begin
                        r_dfound <= 1'b1;
                        r_didx   <= w_pos_i - 1'b1;
                    end
                end
                r_pos <= r_pos + 1'b1;
            end
            if (i_cmd.do_append && !o_stat.full) r_total <= r_total + 1'b1;
            if (i_cmd.do_flush) r_total <= '0;
            if (i_cmd.cnt_rd) begin
                r_permit <= r_pfound;
                r_found  <= r_pfound || r_dfound;
                r_hit    <= w_tgt;
            end
            if (i_cmd.cnt_wr) begin
                if (r_permit) r_allow_tot <= sat_inc(r_allow_tot);
                else          r_deny_tot  <= sat_inc(r_deny_tot);
            end
            if (i_cmd.rd_issue) begin
                r_rd_stat <= (r_act == ActAppend) ? o_stat.full : o_stat.idx_bad;
            end
        end
    end

    // result word: fields packed lowest first
    always_comb begin
        logic [RuleCountW-1:0] tot;
        tot      = RuleCountW'(r_total);
        o_result = '0;
        o_result[102:96] = tot;
        case (r_act)
            ActCheck: begin
                o_result[0]   = r_permit;
                o_result[3]   = r_found;
                o_result[9:4] = r_found ? LabelW'(r_hit) : '0;
            end
            ActAppend: o_result[2:1] = r_rd_stat ? StFull : StOk;
            ActFlush:  o_result[2:1] = StOk;
            default: begin
                if (r_rd_stat) begin
                    o_result[2:1] = StIdx;
                end else begin
                    o_result[9:4]   = r_ridx;
                    o_result[15:10] = r_rd_rule.subj;
                    o_result[16]    = r_rd_rule.subj_any;
                    o_result[22:17] = r_rd_rule.obj;
                    o_result[23]    = r_rd_rule.obj_any;
                    o_result[31:24] = r_rd_rule.mask;
                    o_result[63:32] = r_cnt_a;
                    o_result[95:64] = r_cnt_d;
                end
            end
        endcase
    end

endmodule

// ----- sv/fmart_ctrl.sv -----
// controller state machine of the rule table
// depends on fmart_pkg, steers fmart_datapath
`timescale 1ns / 1ps

module fmart_ctrl import fmart_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_act,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_stat      i_stat,
    output t_cmd       o_cmd
);
    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_SCAN, S_CNT_RD, S_CNT_WR, S_READ, S_READ2, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic [1:0] r_act;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                o_cmd.do_flush = (r_act == ActFlush);
                if (i_stat.clr_done) n_state = (r_act == ActFlush) ? S_OUT : S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_act)
                        ActCheck:  n_state = S_SCAN;
                        ActRead:   n_state = S_READ;
                        ActAppend: n_state = S_READ2;
                        default:   n_state = S_CLEAR;
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_done) n_state = S_CNT_RD;
            end
            S_CNT_RD: begin
                o_cmd.cnt_rd = 1'b1;
                n_state      = S_CNT_WR;
            end
            S_CNT_WR: begin
                o_cmd.cnt_wr = 1'b1;
                n_state      = S_OUT;
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                o_cmd.cnt_rd   = 1'b0;
                n_state        = S_OUT;
            end
            S_READ2: begin
                o_cmd.rd_issue  = 1'b1;
                o_cmd.do_append = 1'b1;
                n_state         = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_act   <= ActCheck;
        end else begin
            r_state <= n_state;
            if (o_cmd.load) r_act <= i_act;
        end
    end

endmodule

// ----- sv/first_match_access_rule_table.sv -----
// First-match access rule table. One transfer is taken at a time. A check
// walks the rules in order, one per cycle through the rule memory read port.
// Flush and reset both sweep the counter memories one entry a cycle, and
// after reset no transfer is accepted until the sweep is done. A result that
// waits for the receiver holds off the input.
// depends on fmart_pkg, fmart_ctrl, fmart_datapath
`timescale 1ns / 1ps

module first_match_access_rule_table import fmart_pkg::*; #(
    parameter int MAX_RULES   = MaxRulesDefault,
    parameter int LABEL_COUNT = LabelCountDefault
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // action, subject, subject_any, object, object_any,
    // operation_mask, rule_index
    input  logic [31:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // permit, status, matched_found, matched_index, entry_subject,
    // entry_subject_any, entry_object, entry_object_any, entry_mask,
    // entry_allow_hits, entry_deny_hits, rules_in_use
    output logic [103:0] m_axis_tdata
);
    t_cmd  w_cmd;
    t_stat w_stat;
    logic [29:0] w_data;

    // repack to the order the datapath loads
    assign w_data = {s_axis_tdata[1:0], s_axis_tdata[7:2], s_axis_tdata[8],
                     s_axis_tdata[14:9], s_axis_tdata[15], s_axis_tdata[23:16],
                     s_axis_tdata[29:24]};

    fmart_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_act       (s_axis_tdata[1:0]),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    fmart_datapath #(
        .MAX_RULES   (MAX_RULES),
        .LABEL_COUNT (LABEL_COUNT)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .i_data   (w_data),
        .o_result (m_axis_tdata)
    );

endmodule

// ----- sv/fmart_checker.sv -----
// port-level checks on the rule table
// bound to first_match_access_rule_table
`timescale 1ns / 1ps

module fmart_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [103:0] m_axis_tdata
);
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready during result");
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second transfer taken");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result dropped");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[102:96] <= 7'd64)) else $error("count range");
endmodule

bind first_match_access_rule_table fmart_checker u_chk (.*);

// ----- verif/first_match_access_rule_table_test.sv -----
// testbench for first_match_access_rule_table: directed table, fill to overflow, then random transfers
// results compared as a whole against a behavioural predictor; needs fmart_pkg
`timescale 1ns / 1ps

module first_match_access_rule_table_test;
    import fmart_pkg::*;

    localparam int NRULES = 64;

    typedef struct packed {
        logic [5:0]  rule_index;
        logic [7:0]  op_mask;
        logic        obj_any;
        logic [5:0]  obj;
        logic        subj_any;
        logic [5:0]  subj;
        logic [1:0]  action;
    } t_req;

    typedef struct packed {
        logic [6:0]  in_use;
        logic [31:0] deny_hits;
        logic [31:0] allow_hits;
        logic [7:0]  e_mask;
        logic        e_obj_any;
        logic [5:0]  e_obj;
        logic        e_subj_any;
        logic [5:0]  e_subj;
        logic [5:0]  m_index;
        logic        m_found;
        logic [1:0]  status;
        logic        permit;
    } t_resp;

    typedef struct {
        t_req  req;
        logic  known;
        t_resp resp;
    } t_row;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata = '0;   // action, subject, subject_any, object, object_any, mask, index
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [103:0] m_axis_tdata;        // permit, status, found, index, entry fields, rules_in_use

    first_match_access_rule_table DUT (.*);

    always #10 i_clk = ~i_clk;

    // predictor state
    t_rule       acl [NRULES];
    logic [31:0] allow_cnt [NRULES];
    logic [31:0] deny_cnt [NRULES];
    int          acl_used;
    logic [31:0] allow_sum, deny_sum;

    t_resp verdicts [$];
    int    errors = 0;
    int    mismatches = 0;
    int    tx_gap = 0, rx_gap = 0;
    bit    rx_hold = 0;
    bit    done = 0;
    int    rx_cnt = 0;

    function automatic logic [31:0] bump(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 1;
    endfunction

    function automatic bit side_hit(logic [5:0] lab, logic any, logic [5:0] req);
        return any || (lab == req);   // labels all below LABEL_COUNT at 6 bits
    endfunction

    function automatic t_resp decide(t_req r);
        t_resp o;
        int hit;
        bit lm;
        o = '0;
        hit = -1;
        case (r.action)
            ActCheck: begin
                for (int i = 0; i < acl_used && hit < 0; i++) begin
                    lm = side_hit(acl[i].subj, acl[i].subj_any, r.subj) &&
                         side_hit(acl[i].obj, acl[i].obj_any, r.obj);
                    if (lm && (acl[i].mask & r.op_mask) != 0) hit = i;
                end
                if (hit >= 0) begin
                    o.permit = 1;
                    allow_cnt[hit] = bump(allow_cnt[hit]);
                    allow_sum = bump(allow_sum);
                end else begin
                    for (int i = 0; i < acl_used && hit < 0; i++)
                        if (side_hit(acl[i].subj, acl[i].subj_any, r.subj) &&
                            side_hit(acl[i].obj, acl[i].obj_any, r.obj)) hit = i;
                    if (hit >= 0) deny_cnt[hit] = bump(deny_cnt[hit]);
                    deny_sum = bump(deny_sum);
                end
                o.m_found = hit >= 0;
                o.m_index = (hit >= 0) ? hit[5:0] : 6'd0;
            end
            ActAppend: begin
                if (acl_used >= NRULES) o.status = StFull;
                else begin
                    acl[acl_used] = '{r.subj, r.subj_any, r.obj, r.obj_any, r.op_mask};
                    allow_cnt[acl_used] = 0;
                    deny_cnt[acl_used] = 0;
                    acl_used++;
                end
            end
            ActFlush: begin
                for (int i = 0; i < NRULES; i++) begin
                    allow_cnt[i] = 0;
                    deny_cnt[i] = 0;
                end
                acl_used = 0;
            end
            default: begin
                if (r.rule_index >= acl_used) o.status = StIdx;
                else begin
                    o.m_index    = r.rule_index;
                    o.e_subj     = acl[r.rule_index].subj;
                    o.e_subj_any = acl[r.rule_index].subj_any;
                    o.e_obj      = acl[r.rule_index].obj;
                    o.e_obj_any  = acl[r.rule_index].obj_any;
                    o.e_mask     = acl[r.rule_index].mask;
                    o.allow_hits = allow_cnt[r.rule_index];
                    o.deny_hits  = deny_cnt[r.rule_index];
                end
            end
        endcase
        o.in_use = acl_used[6:0];
        return o;
    endfunction

    function automatic t_req mk(int a, int s, int sa, int ob, int oa, int m, int ix);
        t_req r;
        r = '{6'(ix), 8'(m), 1'(oa), 6'(ob), 1'(sa), 6'(s), 2'(a)};
        return r;
    endfunction

    task automatic send(t_req r, logic known, t_resp want);
        t_resp p;
        while (tx_gap > 0 && $urandom_range(99) < tx_gap) begin
            s_axis_tvalid <= 0;
            @(negedge i_clk);
        end
        s_axis_tdata  <= {2'd0, r};
        s_axis_tvalid <= 1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        p = decide(r);
        if (known && p !== want) begin
            errors++;
            if (mismatches++ < 10)
                $display("directed row disagrees with predictor: %h vs %h", want, p);
        end
        verdicts.push_back(p);
        @(negedge i_clk);
    endtask

    // receiver
    always @(negedge i_clk)
        m_axis_tready <= !rx_hold && !(rx_gap > 0 && $urandom_range(99) < rx_gap);

    always @(posedge i_clk)
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_resp got, want;
            got = t_resp'(m_axis_tdata[102:0]);
            rx_cnt++;
            if (verdicts.size() == 0) begin
                errors++;
                if (mismatches++ < 10) $display("unexpected transfer %h", got);
            end else begin
                want = verdicts.pop_front();
                if (got !== want) begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("mismatch: expected %h actual %h", want, got);
                end
            end
        end

    // long receiver hold-off, counted in its own process
    initial begin
        wait (rx_cnt > 300);
        @(negedge i_clk);
        rx_hold = 1;
        repeat (400) @(negedge i_clk);
        rx_hold = 0;
    end

    task automatic drain();
        s_axis_tvalid <= 0;
        @(negedge i_clk);
        while (verdicts.size() != 0) @(negedge i_clk);
    endtask

    function automatic t_req rnd_req(int phase);
        t_req r;
        int sel;
        r = t_req'(30'($urandom));
        sel = $urandom_range(99);
        r.subj = (phase % 2) ? 6'($urandom_range(3)) : r.subj;
        r.obj  = (phase % 2) ? 6'($urandom_range(3)) : r.obj;
        r.subj_any = $urandom_range(99) < 20;
        r.obj_any  = $urandom_range(99) < 20;
        if (sel < 55) r.action = ActCheck;
        else if (sel < 85) r.action = ActAppend;
        else if (sel < 87) r.action = ActFlush;
        else begin
            r.action = ActRead;
            r.rule_index = (acl_used > 0 && sel < 97) ? 6'($urandom_range(acl_used - 1))
                                                      : r.rule_index;
        end
        if (r.action == ActCheck && $urandom_range(3) != 0) r.op_mask = 8'd1 << $urandom_range(7);
        return r;
    endfunction

    t_row rows [$];

    initial begin
        t_resp z;
        acl_used = 0;
        allow_sum = 0;
        deny_sum = 0;
        for (int i = 0; i < NRULES; i++) begin
            acl[i] = '0;
            allow_cnt[i] = 0;
            deny_cnt[i] = 0;
        end
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1;

        // directed table
        z = '0;
        rows.push_back('{mk(ActCheck, 0, 0, 0, 0, 8'hFF, 0), 1, z});
        z.status = StIdx;
        rows.push_back('{mk(ActRead, 0, 0, 0, 0, 0, 0), 1, z});
        z = '0; z.in_use = 1;
        rows.push_back('{mk(ActAppend, 6'd63, 0, 6'd0, 0, 8'h80, 0), 1, z});
        rows.push_back('{mk(ActAppend, 0, 1, 6'd63, 0, 8'h01, 0), 0, z});
        rows.push_back('{mk(ActAppend, 5, 1, 9, 1, 8'h00, 0), 0, z});
        rows.push_back('{mk(ActCheck, 6'd63, 0, 6'd0, 0, 8'h80, 0), 0, z});
        rows.push_back('{mk(ActCheck, 6'd63, 0, 6'd0, 0, 8'h7F, 0), 0, z});
        rows.push_back('{mk(ActCheck, 6'd12, 0, 6'd63, 0, 8'h00, 0), 0, z});
        rows.push_back('{mk(ActCheck, 6'd12, 0, 6'd5, 0, 8'hFF, 0), 0, z});
        rows.push_back('{mk(ActRead, 0, 0, 0, 0, 0, 6'd0), 0, z});
        rows.push_back('{mk(ActRead, 0, 0, 0, 0, 0, 6'd2), 0, z});
        rows.push_back('{mk(ActRead, 0, 0, 0, 0, 0, 6'd63), 0, z});
        z = '0;
        rows.push_back('{mk(ActFlush, 0, 0, 0, 0, 0, 0), 1, z});
        rows.push_back('{mk(ActRead, 0, 0, 0, 0, 0, 0), 0, z});
        foreach (rows[i]) send(rows[i].req, rows[i].known, rows[i].resp);

        // fill to full, then overflow
        for (int i = 0; i < NRULES + 2; i++)
            send(mk(ActAppend, i, 0, 63 - i, 0, 8'hFF - i, 0), 0, z);
        send(mk(ActRead, 0, 0, 0, 0, 0, 6'd63), 0, z);
        send(mk(ActCheck, 6'd63, 0, 6'd0, 0, 8'h01, 0), 0, z);
        send(mk(ActFlush, 0, 0, 0, 0, 0, 0), 0, z);

        for (int n = 0; n < 1900; n++) begin
            case ((n / 240) % 4)
                0: begin tx_gap = 0;  rx_gap = 0;  end
                1: begin tx_gap = 57; rx_gap = 0;  end
                2: begin tx_gap = 0;  rx_gap = 57; end
                default: begin tx_gap = 22; rx_gap = 22; end
            endcase
            if (n == 1000) drain();
            send(rnd_req(n / 120), 0, z);
        end
        drain();
        repeat (200) @(negedge i_clk);
        done = 1;
        if (errors == 0 && verdicts.size() == 0)
            $display("first_match_access_rule_table test passed");
        else
            $display("first_match_access_rule_table test failed");
        $finish;
    end

    initial begin
        #40ms;
        if (!done) begin
            $display("first_match_access_rule_table test failed");
            $finish;
        end
    end
endmodule
